### rtl/fdm_pkg.sv
// shared constants and register codes for the feedback delay mixer
package fdm_pkg;

  // default store address width (depth is a power of two) and sample width
  localparam int unsigned STORE_AW_DEF = 17;
  localparam int unsigned SAMPLE_W_DEF = 16;

  // register field widths
  localparam int unsigned DELAY_W    = 17;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // register reset values
  localparam logic [DELAY_W-1:0]        DELAY_RST = 17'd1;
  localparam logic signed [GAIN_W-1:0]  FB_RST    = 16'sd0;
  localparam logic [GAIN_W-1:0]         DRY_RST   = 16'd16384;
  localparam logic [GAIN_W-1:0]         WET_RST   = 16'd16384;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_DRY      = 2'd2,
    REG_WET      = 2'd3
  } cfg_reg_e;

endpackage

### rtl/fdm_ram.sv
// delay store clocked by clk_i alone, one write and one registered read port
module fdm_ram #(
  parameter int unsigned ADDR_W = 17,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];
  logic [DATA_W-1:0] rd_data_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/feedback_delay_mix.sv
// top level of the feedback delay echo mixer
//
// channel   | dir | handshake                 | payload
// ----------+-----+---------------------------+-------------------------------
// s_axis    | in  | s_axis_tvalid/tready      | tdata: sample_in
// m_axis    | out | m_axis_tvalid/tready      | tdata: sample_out
// cfg       | in  | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// one sample per clock sustained while the output is not stalled; each result
// passes the store read and stage 1 registers, then the output register
// reset clears control only; the store is not swept, a fill flag makes any
// entry not yet written since reset read as zero, so samples flow at once
// a stalled output freezes every stage and drops tready on the input side
module feedback_delay_mix
  import fdm_pkg::*;
#(
  parameter int unsigned STORE_AW = STORE_AW_DEF,  // store depth is 2**STORE_AW
  parameter int unsigned SAMPLE_W = SAMPLE_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_W + 7) / 8) * 8-1:0] s_axis_tdata,   // [SAMPLE_W-1:0] sample_in
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_W + 7) / 8) * 8-1:0] m_axis_tdata,   // [SAMPLE_W-1:0] sample_out
  // register write port
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata_i
);

  localparam int unsigned TDATA_W   = ((SAMPLE_W + 7) / 8) * 8;
  localparam int unsigned DLY_EXT_W = (STORE_AW > DELAY_W) ? STORE_AW : DELAY_W;
  // feedback product plus rounding headroom
  localparam int unsigned FBPW      = GAIN_W + SAMPLE_W + 1;
  // mix sum width, also used as the common saturation input width
  localparam int unsigned MIXW      = GAIN_W + SAMPLE_W + 2;

  localparam logic signed [FBPW-1:0] FB_HALF  = FBPW'(16384);
  localparam logic signed [MIXW-1:0] MIX_HALF = MIXW'(8192);
  localparam logic signed [MIXW-1:0] SAT_HI   =
    {{(MIXW - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
  localparam logic signed [MIXW-1:0] SAT_LO   = ~SAT_HI;

  function automatic logic [SAMPLE_W-1:0] sat_f(input logic signed [MIXW-1:0] v);
    logic signed [MIXW-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[SAMPLE_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [DELAY_W-1:0]       delay_q;
  logic signed [GAIN_W-1:0] fb_gain_q;
  logic [GAIN_W-1:0]        dry_gain_q;
  logic [GAIN_W-1:0]        wet_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= DELAY_RST;
      fb_gain_q  <= FB_RST;
      dry_gain_q <= DRY_RST;
      wet_gain_q <= WET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DELAY:    delay_q    <= cfg_wdata_i[DELAY_W-1:0];
        REG_FEEDBACK: fb_gain_q  <= signed'(cfg_wdata_i[GAIN_W-1:0]);
        REG_DRY:      dry_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_WET:      wet_gain_q <= cfg_wdata_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // flow control: the whole pipe advances together
  // ---------------------------------------------------------------------
  logic out_valid_q;
  logic adv;
  logic in_xfer;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_xfer       = s_axis_tvalid && adv;

  // ---------------------------------------------------------------------
  // stage 0: write pointer, read address, fill tracking
  // ---------------------------------------------------------------------
  logic [STORE_AW-1:0]  wp_q;
  logic                 full_q;   // store has wrapped once, every entry written
  logic [DLY_EXT_W-1:0] dly_ext;
  logic [STORE_AW-1:0]  rd_addr;
  logic                 rd_written;
  logic signed [SAMPLE_W-1:0] x_in;

  assign x_in       = signed'(s_axis_tdata[SAMPLE_W-1:0]);
  assign dly_ext    = DLY_EXT_W'(delay_q);
  // delay modulo depth is the low address bits
  assign rd_addr    = wp_q - dly_ext[STORE_AW-1:0];
  // entries below the pointer were written since reset, all of them once full
  assign rd_written = full_q || (rd_addr < wp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      full_q <= 1'b0;
    end else if (in_xfer) begin
      wp_q <= wp_q + 1'b1;
      if (&wp_q) begin
        full_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // delay store
  // ---------------------------------------------------------------------
  logic                       s1_valid_q;
  logic [STORE_AW-1:0]        s1_waddr_q;
  logic signed [SAMPLE_W-1:0] s1_x_q;
  logic                       s1_written_q;
  logic                       s1_fwd_q;     // previous sample wrote this entry on the read edge
  logic [SAMPLE_W-1:0]        s1_fwd_data_q;
  logic [SAMPLE_W-1:0]        ram_rd_data;
  logic [SAMPLE_W-1:0]        store_val;
  logic                       ram_we;

  assign ram_we = adv && s1_valid_q;

  fdm_ram #(
    .ADDR_W (STORE_AW),
    .DATA_W (SAMPLE_W)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_xfer),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_we),
    .wr_addr_i (s1_waddr_q),
    .wr_data_i (store_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_waddr_q    <= wp_q;
      s1_x_q        <= x_in;
      s1_written_q  <= rd_written;
      s1_fwd_q      <= s1_valid_q && (rd_addr == s1_waddr_q);
      s1_fwd_data_q <= store_val;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: delayed sample, feedback write-back, wet/dry mix
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0]       y;
  logic signed [GAIN_W+SAMPLE_W-1:0] fb_prod;
  logic signed [FBPW-1:0]           fb_sum;
  logic signed [FBPW-1:0]           fb_shift;
  logic signed [MIXW-1:0]           store_sum;
  logic signed [GAIN_W:0]           dry_s;
  logic signed [GAIN_W:0]           wet_s;
  logic signed [GAIN_W+SAMPLE_W:0]  dry_prod;
  logic signed [GAIN_W+SAMPLE_W:0]  wet_prod;
  logic signed [MIXW-1:0]           mix_sum;
  logic signed [MIXW-1:0]           mix_shift;

  always_comb begin
    if (s1_fwd_q) begin
      y = signed'(s1_fwd_data_q);
    end else if (s1_written_q) begin
      y = signed'(ram_rd_data);
    end else begin
      y = '0;
    end
  end

  // feedback: round half up then saturate into the store
  assign fb_prod   = fb_gain_q * y;
  assign fb_sum    = FBPW'(fb_prod) + FB_HALF;
  assign fb_shift  = fb_sum >>> 15;
  assign store_sum = MIXW'(s1_x_q) + MIXW'(fb_shift);
  assign store_val = sat_f(store_sum);

  // mix: unsigned Q2.14 gains on the dry input and the delayed sample
  assign dry_s     = signed'({1'b0, dry_gain_q});
  assign wet_s     = signed'({1'b0, wet_gain_q});
  assign dry_prod  = dry_s * s1_x_q;
  assign wet_prod  = wet_s * y;
  assign mix_sum   = MIXW'(dry_prod) + MIXW'(wet_prod) + MIX_HALF;
  assign mix_shift = mix_sum >>> 14;

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_data_q <= sat_f(mix_shift);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'(out_data_q);

endmodule
